// ----- hw/rtl/ssca_pkg.sv -----
// Shared constants, codes and control types of the slab size class allocator.
`timescale 1ns / 1ps

package ssca_pkg;

  // Pool geometry.
  localparam int PAGE_BYTES     = 4096;
  localparam int MAX_PAGES      = 64;
  localparam int MAX_CLASSES    = 16;
  localparam int MIN_ITEM_BYTES = 8;

  localparam int SLOTS_MAX  = PAGE_BYTES / MIN_ITEM_BYTES;
  localparam int SLOT_TOTAL = MAX_PAGES * SLOTS_MAX;

  // Derived widths.
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int SLOT_W     = $clog2(SLOTS_MAX);
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int SID_W      = PAGE_W + SLOT_W;
  localparam int CLS_W      = $clog2(MAX_CLASSES);
  localparam int CCNT_W     = $clog2(MAX_CLASSES + 1);
  localparam int PCNT_W     = $clog2(MAX_PAGES + 1);
  localparam int ISZ_W      = $clog2(PAGE_BYTES + 1);
  localparam int SPP_W      = $clog2(SLOTS_MAX + 1);
  localparam int DIV_W      = ISZ_W;
  localparam int DCNT_W     = $clog2(DIV_W);

  // Field widths.
  localparam int OP_W      = 2;
  localparam int BYTES_W   = 19;
  localparam int ADDR_W    = 18;
  localparam int GROWTH_W  = 16;
  localparam int STATUS_W  = 3;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = ISZ_W + GROWTH_W;
  localparam int NS_W      = PROD_W - FRAC_W;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_POOL_LIMIT = 1'b0;
  localparam logic REG_GROWTH     = 1'b1;

  localparam logic [BYTES_W-1:0]  POOL_LIMIT_RESET = 19'd262144;
  localparam logic [GROWTH_W-1:0] GROWTH_RESET     = 16'd512;

  // Request codes.
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_PAGE   = 3'd2,
    ST_CLASS_ERR = 3'd3,
    ST_BAD_ADDR  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_GROW_TOP,
    S_GROW_MUL,
    S_GROW_CHK,
    S_GROW_DIV,
    S_ALLOC,
    S_CARVE,
    S_POP_RD,
    S_POP_WR,
    S_REL_PAGE,
    S_REL_CLS,
    S_REL_DIVS,
    S_REL_DIV,
    S_REL_RD,
    S_REL_WR,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    cur_clear;
    logic    cur_inc;
    logic    ns_from_size;
    logic    ns_from_mul;
    logic    append;
    logic    grow_commit;
    logic    set_status;
    status_t status_code;
    logic    set_cls;
    logic    carve_start;
    logic    carve_step;
    logic    pop;
    logic    cur_from_owner;
    logic    rel_div_start;
    logic    slot_latch;
    logic    rel_free;
    logic    out_load;
  } cmd_t;

  // Conditions reported by the datapath.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic bad_size;
    logic search_end;
    logic search_hit;
    logic table_full;
    logic count_zero;
    logic grow_bad;
    logic grow_more;
    logic div_done;
    logic cls_nonempty;
    logic carve_bad;
    logic carve_last;
    logic page_ok;
    logic slot_ok;
    logic in_use;
    logic out_free;
  } stat_t;

endpackage

// ----- hw/rtl/slab_size_class_allocator.sv -----
// Top level of the slab size class allocator.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake              Carries
// config    in         psel/penable/pready    pool limit, growth ratio (APB)
// request   in         req_valid/req_ready    op, request_size, block_address
// response  out        rsp_valid/rsp_ready    status, granted_address, size_class,
//                                             used_bytes, page_bytes, free_bytes
//
// One request is handled at a time. An allocate searches the classes in turn,
// appends classes through the shared divider as needed and, when a page is
// carved, sets up its slots one at a time (up to 512). A release checks the
// block address with the same shared divider.
// Reset clears the counters and list flags at once; a page's slot bits are
// cleared while it is carved, so no clearing pass is needed.
// A result waits in the output register while the next request is taken.

module slab_size_class_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssca_pkg::APB_AW-1:0]   paddr,
  input  logic [ssca_pkg::APB_DW-1:0]   pwdata,
  output logic [ssca_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [ssca_pkg::OP_W-1:0]     op,
  input  logic [ssca_pkg::BYTES_W-1:0]  request_size,
  input  logic [ssca_pkg::ADDR_W-1:0]   block_address,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [ssca_pkg::STATUS_W-1:0] status,
  output logic [ssca_pkg::ADDR_W-1:0]   granted_address,
  output logic [ssca_pkg::CLS_W-1:0]    size_class,
  output logic [ssca_pkg::BYTES_W-1:0]  used_bytes,
  output logic [ssca_pkg::BYTES_W-1:0]  page_bytes,
  output logic [ssca_pkg::BYTES_W-1:0]  free_bytes
);
  import ssca_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  ssca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  ssca_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .op              (op),
    .request_size    (request_size),
    .block_address   (block_address),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .status          (status),
    .granted_address (granted_address),
    .size_class      (size_class),
    .used_bytes      (used_bytes),
    .page_bytes      (page_bytes),
    .free_bytes      (free_bytes),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// ----- hw/rtl/ssca_div.sv -----
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps

module ssca_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ssca_pkg::DIV_W-1:0] dividend,
  input  logic [ssca_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [ssca_pkg::DIV_W-1:0] quotient,
  output logic [ssca_pkg::DIV_W-1:0] remainder
);
  import ssca_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W:0]    shifted;
  logic [DIV_W+1:0]  diff;
  logic              ge;

  // One trial subtraction per cycle.
  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign ge      = !diff[DIV_W+1];

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DCNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- hw/rtl/ssca_datapath.sv -----
// Datapath of the allocator: registers, class tables, free lists and slot memories.
`timescale 1ns / 1ps

module ssca_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssca_pkg::APB_AW-1:0]   paddr,
  input  logic [ssca_pkg::APB_DW-1:0]   pwdata,
  output logic [ssca_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic [ssca_pkg::OP_W-1:0]     op,
  input  logic [ssca_pkg::BYTES_W-1:0]  request_size,
  input  logic [ssca_pkg::ADDR_W-1:0]   block_address,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [ssca_pkg::STATUS_W-1:0] status,
  output logic [ssca_pkg::ADDR_W-1:0]   granted_address,
  output logic [ssca_pkg::CLS_W-1:0]    size_class,
  output logic [ssca_pkg::BYTES_W-1:0]  used_bytes,
  output logic [ssca_pkg::BYTES_W-1:0]  page_bytes,
  output logic [ssca_pkg::BYTES_W-1:0]  free_bytes,
  input  ssca_pkg::cmd_t                cmd,
  output ssca_pkg::stat_t               stat
);
  import ssca_pkg::*;

  // Configuration registers.
  logic [BYTES_W-1:0]  pool_limit;
  logic [GROWTH_W-1:0] growth_ratio;

  // Latched request.
  logic [OP_W-1:0]    op_r;
  logic [BYTES_W-1:0] req_r;
  logic [ADDR_W-1:0]  addr_r;

  // Class table and free lists.
  logic [ISZ_W-1:0]  class_size [MAX_CLASSES];
  logic [SPP_W-1:0]  spp       [MAX_CLASSES];
  logic [SID_W-1:0]  head      [MAX_CLASSES];
  logic [SID_W-1:0]  tail      [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] nonempty;
  logic [CCNT_W-1:0] class_count;
  logic [ISZ_W-1:0]  last_size;

  // Working registers.
  logic [CCNT_W-1:0] cur;
  logic [NS_W-1:0]   ns_r;
  logic [SLOT_W-1:0] k_r;
  logic [SID_W-1:0]  slot_r;
  logic [PCNT_W-1:0] pages_carved;
  logic [BYTES_W-1:0] used_total;

  // Result being built and the output register.
  status_t           status_r;
  logic [ADDR_W-1:0] granted_r;
  logic [CLS_W-1:0]  cls_r;

  // Slot and page memories.
  logic [SID_W-1:0] link_mem  [SLOT_TOTAL];
  logic             inuse_mem [SLOT_TOTAL];
  logic [CLS_W-1:0] owner_mem [MAX_PAGES];
  logic [SID_W-1:0] link_rd;
  logic             inuse_rd;
  logic [CLS_W-1:0] owner_rd;

  // Divider connections.
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;

  // Values of the selected class and derived quantities.
  logic [CLS_W-1:0]        ci;
  logic [ISZ_W-1:0]        isz_cur;
  logic [SPP_W-1:0]        spp_cur;
  logic [SID_W-1:0]        head_cur;
  logic [ISZ_W-1:0]        size_w;
  logic [PROD_W-1:0]       prod;
  logic [PAGE_W-1:0]       pc_idx;
  logic [PAGE_W-1:0]       rel_page;
  logic [SID_W-1:0]        carve_sid;
  logic [SLOT_W+ISZ_W-1:0] slot_off;
  logic [PCNT_W+PAGE_SHIFT:0] carve_end;

  assign ci       = cur[CLS_W-1:0];
  assign isz_cur  = class_size[ci];
  assign spp_cur  = spp[ci];
  assign head_cur = head[ci];
  assign pc_idx   = pages_carved[PAGE_W-1:0];
  assign rel_page = addr_r[ADDR_W-1:PAGE_SHIFT];
  assign carve_sid = {pc_idx, k_r};
  assign prod     = last_size * growth_ratio;
  assign slot_off = head_cur[SLOT_W-1:0] * isz_cur;
  assign carve_end = {(PCNT_W+1)'(pages_carved) + 1'b1, {PAGE_SHIFT{1'b0}}};

  // Request size raised to the smallest item.
  assign size_w = (req_r < BYTES_W'(MIN_ITEM_BYTES)) ? ISZ_W'(MIN_ITEM_BYTES)
                                                    : req_r[ISZ_W-1:0];

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit   <= POOL_LIMIT_RESET;
      growth_ratio <= GROWTH_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[APB_AW-1])
        REG_POOL_LIMIT: pool_limit   <= pwdata[BYTES_W-1:0];
        REG_GROWTH:     growth_ratio <= pwdata[GROWTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_AW-1])
      REG_POOL_LIMIT: prdata = APB_DW'(pool_limit);
      default:        prdata = APB_DW'(growth_ratio);
    endcase
  end

  // Division shared by class growth and release checks.
  assign div_start    = cmd.append || cmd.rel_div_start;
  assign div_dividend = cmd.append ? DIV_W'(PAGE_BYTES)
                                   : DIV_W'(addr_r[PAGE_SHIFT-1:0]);
  assign div_divisor  = cmd.append ? ns_r[DIV_W-1:0] : isz_cur;

  ssca_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Control state: counters, list flags and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count  <= '0;
      pages_carved <= '0;
      used_total   <= '0;
      nonempty     <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cmd.grow_commit) begin
        class_count <= class_count + 1'b1;
      end
      if (cmd.carve_step && stat.carve_last) begin
        pages_carved  <= pages_carved + 1'b1;
        nonempty[ci]  <= 1'b1;
      end
      if (cmd.pop) begin
        used_total <= used_total + BYTES_W'(isz_cur);
        if (head_cur == tail[ci]) begin
          nonempty[ci] <= 1'b0;
        end
      end
      if (cmd.rel_free) begin
        used_total   <= used_total - BYTES_W'(isz_cur);
        nonempty[ci] <= 1'b1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request latch and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op;
      req_r     <= request_size;
      addr_r    <= block_address;
      status_r  <= ST_OK;
      granted_r <= '0;
      cls_r     <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.set_cls || cmd.pop || cmd.rel_free) begin
      cls_r <= ci;
    end
    if (cmd.cur_clear) begin
      cur <= '0;
    end else if (cmd.cur_inc) begin
      cur <= cur + 1'b1;
    end else if (cmd.append) begin
      cur <= class_count;
    end else if (cmd.cur_from_owner) begin
      cur <= CCNT_W'(owner_rd);
    end
    if (cmd.ns_from_size) begin
      ns_r <= NS_W'(size_w);
    end else if (cmd.ns_from_mul) begin
      ns_r <= prod[PROD_W-1:FRAC_W];
    end
    if (cmd.carve_start) begin
      k_r <= '0;
    end else if (cmd.carve_step) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.slot_latch) begin
      slot_r <= {rel_page, div_quo[SLOT_W-1:0]};
    end
    if (cmd.pop) begin
      granted_r <= {head_cur[SID_W-1:SLOT_W], slot_off[PAGE_SHIFT-1:0]};
    end
  end

  // Class table and list pointers.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      class_size[class_count[CLS_W-1:0]] <= ns_r[ISZ_W-1:0];
      last_size <= ns_r[ISZ_W-1:0];
    end
    if (cmd.grow_commit) begin
      spp[ci] <= div_quo[SPP_W-1:0];
    end
    if (cmd.carve_step && stat.carve_last) begin
      head[ci] <= {pc_idx, {SLOT_W{1'b0}}};
      tail[ci] <= carve_sid;
    end
    if (cmd.pop && head_cur != tail[ci]) begin
      head[ci] <= link_rd;
    end
    if (cmd.rel_free) begin
      head[ci] <= slot_r;
      if (!nonempty[ci]) begin
        tail[ci] <= slot_r;
      end
    end
  end

  // Page owner memory.
  always_ff @(posedge clk) begin
    if (cmd.carve_start) begin
      owner_mem[pc_idx] <= ci;
    end
    owner_rd <= owner_mem[rel_page];
  end

  // Free list link memory.
  always_ff @(posedge clk) begin
    if (cmd.carve_step) begin
      link_mem[carve_sid] <= carve_sid + 1'b1;
    end else if (cmd.rel_free && nonempty[ci]) begin
      link_mem[slot_r] <= head_cur;
    end
    link_rd <= link_mem[head_cur];
  end

  // Slot in-use memory; a page's bits are cleared as it is carved.
  always_ff @(posedge clk) begin
    if (cmd.carve_step) begin
      inuse_mem[carve_sid] <= 1'b0;
    end else if (cmd.pop) begin
      inuse_mem[head_cur] <= 1'b1;
    end else if (cmd.rel_free) begin
      inuse_mem[slot_r] <= 1'b0;
    end
    inuse_rd <= inuse_mem[slot_r];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status          <= status_r;
      granted_address <= granted_r;
      size_class      <= cls_r;
      used_bytes      <= used_total;
      page_bytes      <= BYTES_W'({pages_carved, {PAGE_SHIFT{1'b0}}});
      free_bytes      <= BYTES_W'({pages_carved, {PAGE_SHIFT{1'b0}}}) - used_total;
    end
  end

  // Conditions for the controller.
  always_comb begin
    stat.op           = op_r;
    stat.bad_size     = (req_r == '0) || (req_r > pool_limit)
                        || (req_r > BYTES_W'(PAGE_BYTES));
    stat.search_end   = (cur == class_count);
    stat.search_hit   = (isz_cur >= size_w);
    stat.table_full   = (class_count >= CCNT_W'(MAX_CLASSES));
    stat.count_zero   = (class_count == '0);
    stat.grow_bad     = (!stat.count_zero && ns_r <= NS_W'(last_size))
                        || (ns_r > NS_W'(pool_limit)) || (ns_r > NS_W'(PAGE_BYTES));
    stat.grow_more    = (ns_r < NS_W'(size_w));
    stat.div_done     = div_done;
    stat.cls_nonempty = nonempty[ci];
    stat.carve_bad    = (pages_carved >= PCNT_W'(MAX_PAGES))
                        || (carve_end > (PCNT_W+PAGE_SHIFT+1)'(pool_limit));
    stat.carve_last   = ({1'b0, k_r} == spp_cur - 1'b1);
    stat.page_ok      = (PCNT_W'(rel_page) < pages_carved);
    stat.slot_ok      = (div_rem == '0) && (div_quo < DIV_W'(spp_cur));
    stat.in_use       = inuse_rd;
    stat.out_free     = !rsp_valid || rsp_ready;
  end

endmodule

// ----- hw/rtl/ssca_ctrl.sv -----
// Controller state machine that sequences the allocator datapath.
`timescale 1ns / 1ps

module ssca_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ssca_pkg::stat_t stat,
  output ssca_pkg::cmd_t  cmd
);
  import ssca_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.op)
          OP_ALLOC:   state_next = stat.bad_size ? S_FINISH : S_SEARCH;
          OP_RELEASE: state_next = S_REL_PAGE;
          default:    state_next = S_FINISH;
        endcase
      end
      S_SEARCH: begin
        if (stat.search_end) state_next = S_GROW_TOP;
        else if (stat.search_hit) state_next = S_ALLOC;
      end
      S_GROW_TOP: begin
        if (stat.table_full) state_next = S_FINISH;
        else if (stat.count_zero) state_next = S_GROW_CHK;
        else state_next = S_GROW_MUL;
      end
      S_GROW_MUL: state_next = S_GROW_CHK;
      S_GROW_CHK: state_next = stat.grow_bad ? S_FINISH : S_GROW_DIV;
      S_GROW_DIV: begin
        if (stat.div_done) state_next = stat.grow_more ? S_GROW_TOP : S_ALLOC;
      end
      S_ALLOC: begin
        if (stat.cls_nonempty) state_next = S_POP_RD;
        else if (stat.carve_bad) state_next = S_FINISH;
        else state_next = S_CARVE;
      end
      S_CARVE: begin
        if (stat.carve_last) state_next = S_POP_RD;
      end
      S_POP_RD: state_next = S_POP_WR;
      S_POP_WR: state_next = S_FINISH;
      S_REL_PAGE: state_next = stat.page_ok ? S_REL_CLS : S_FINISH;
      S_REL_CLS:  state_next = S_REL_DIVS;
      S_REL_DIVS: state_next = S_REL_DIV;
      S_REL_DIV: begin
        if (stat.div_done) state_next = stat.slot_ok ? S_REL_RD : S_FINISH;
      end
      S_REL_RD: state_next = S_REL_WR;
      S_REL_WR: state_next = S_FINISH;
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_DECODE: begin
        if (stat.op == OP_ALLOC) begin
          if (stat.bad_size) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_BAD_SIZE;
          end else begin
            cmd.cur_clear = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        cmd.cur_inc = !stat.search_end && !stat.search_hit;
      end
      S_GROW_TOP: begin
        if (stat.table_full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_CLASS_ERR;
        end else begin
          cmd.ns_from_size = stat.count_zero;
        end
      end
      S_GROW_MUL: cmd.ns_from_mul = 1'b1;
      S_GROW_CHK: begin
        if (stat.grow_bad) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_CLASS_ERR;
        end else begin
          cmd.append = 1'b1;
        end
      end
      S_GROW_DIV: cmd.grow_commit = stat.div_done;
      S_ALLOC: begin
        if (!stat.cls_nonempty) begin
          if (stat.carve_bad) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_NO_PAGE;
            cmd.set_cls     = 1'b1;
          end else begin
            cmd.carve_start = 1'b1;
          end
        end
      end
      S_CARVE:  cmd.carve_step = 1'b1;
      S_POP_WR: cmd.pop = 1'b1;
      S_REL_PAGE: begin
        if (!stat.page_ok) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_BAD_ADDR;
        end
      end
      S_REL_CLS:  cmd.cur_from_owner = 1'b1;
      S_REL_DIVS: cmd.rel_div_start  = 1'b1;
      S_REL_DIV: begin
        if (stat.div_done) begin
          if (stat.slot_ok) begin
            cmd.slot_latch = 1'b1;
          end else begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_BAD_ADDR;
          end
        end
      end
      S_REL_WR: begin
        if (stat.in_use) begin
          cmd.rel_free = 1'b1;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_BAD_ADDR;
        end
      end
      S_FINISH: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the slab size class allocator.
`timescale 1ns / 1ps

module testbench;
  import ssca_pkg::*;

  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_POOL_LIMIT = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_GROWTH     = 3'd4;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [BYTES_W-1:0] size;
    logic [ADDR_W-1:0]  addr;
  } request_t;

  typedef struct {
    status_t             status;
    logic [ADDR_W-1:0]   granted;
    logic [CLS_W-1:0]    cls;
    logic [BYTES_W-1:0]  used;
    logic [BYTES_W-1:0]  pages;
    logic [BYTES_W-1:0]  free;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic req_valid = 0, req_ready;
  logic [OP_W-1:0] op = '0;
  logic [BYTES_W-1:0] request_size = '0;
  logic [ADDR_W-1:0] block_address = '0;
  logic rsp_valid, rsp_ready = 0;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0] granted_address;
  logic [CLS_W-1:0] size_class;
  logic [BYTES_W-1:0] used_bytes, page_bytes, free_bytes;

  slab_size_class_allocator DUT (.*);

  always #10 clk = ~clk;

  // Mirror of the allocator state.
  int unsigned limit_bytes, growth_q88;
  int unsigned class_bytes [MAX_CLASSES];
  int unsigned slots_per_page [MAX_CLASSES];
  int unsigned class_total;
  int unsigned list_head [MAX_CLASSES];
  int unsigned list_tail [MAX_CLASSES];
  bit          list_filled [MAX_CLASSES];
  int unsigned slot_link [SLOT_TOTAL];
  bit          slot_taken [SLOT_TOTAL];
  int unsigned page_class [MAX_PAGES];
  int unsigned carved_pages, bytes_in_use;

  request_t pending_requests[$];
  answer_t  awaited_answers[$];
  int unsigned live_blocks[$];
  bit req_taken = 0;
  bit calm = 0;
  int errors = 0;
  int cycles = 0;

  // Appends a slot to the tail of a class's free list.
  function automatic void append_slot(int unsigned c, int unsigned s);
    if (list_filled[c]) begin
      slot_link[list_tail[c]] = s;
      list_tail[c] = s;
    end else begin
      list_head[c] = s;
      list_tail[c] = s;
      list_filled[c] = 1;
    end
  endfunction

  // Looks up a class covering the size, appending classes as needed.
  function automatic status_t pick_class(int unsigned want, output int unsigned c);
    longint unsigned grown;
    c = 0;
    for (int i = 0; i < class_total; i++) begin
      if (class_bytes[i] >= want) begin
        c = i;
        return ST_OK;
      end
    end
    do begin
      if (class_total >= MAX_CLASSES) return ST_CLASS_ERR;
      if (class_total == 0) begin
        grown = want;
      end else begin
        grown = (longint'(class_bytes[class_total-1]) * growth_q88) >> FRAC_W;
        if (grown <= class_bytes[class_total-1]) return ST_CLASS_ERR;
      end
      if (grown > limit_bytes || grown > PAGE_BYTES) return ST_CLASS_ERR;
      class_bytes[class_total] = 32'(grown);
      slots_per_page[class_total] = 32'(PAGE_BYTES / grown);
      class_total++;
    end while (grown < want);
    c = class_total - 1;
    return ST_OK;
  endfunction

  // Works out the answer to one request and advances the mirror.
  function automatic answer_t serve_request(request_t r);
    answer_t a;
    int unsigned want, c, s, pg, off, isz;
    longint unsigned pb;
    a.status = ST_OK;
    a.granted = '0;
    a.cls = '0;
    if (r.op == OP_ALLOC) begin
      want = 32'(r.size);
      if (want == 0 || want > limit_bytes || want > PAGE_BYTES) begin
        a.status = ST_BAD_SIZE;
      end else begin
        if (want < MIN_ITEM_BYTES) want = MIN_ITEM_BYTES;
        a.status = pick_class(want, c);
        if (a.status != ST_OK) begin
          c = 0;
        end else if (!list_filled[c]) begin
          // A fresh page is carved into slots for this class.
          if (carved_pages >= MAX_PAGES ||
              (carved_pages + 1) * PAGE_BYTES > limit_bytes) begin
            a.status = ST_NO_PAGE;
          end else begin
            page_class[carved_pages] = c;
            for (int k = 0; k < slots_per_page[c]; k++)
              append_slot(c, carved_pages * SLOTS_MAX + k);
            carved_pages++;
          end
        end
        a.cls = CLS_W'(c);
        if (a.status == ST_OK) begin
          s = list_head[c];
          if (s == list_tail[c]) list_filled[c] = 0;
          else list_head[c] = slot_link[s];
          slot_taken[s] = 1;
          bytes_in_use += class_bytes[c];
          a.granted = ADDR_W'((s / SLOTS_MAX) * PAGE_BYTES
                              + (s % SLOTS_MAX) * class_bytes[c]);
          live_blocks = {live_blocks, 32'(a.granted)};
        end
      end
    end else if (r.op == OP_RELEASE) begin
      pg = 32'(r.addr) / PAGE_BYTES;
      off = 32'(r.addr) % PAGE_BYTES;
      a.status = ST_BAD_ADDR;
      if (pg < carved_pages) begin
        c = page_class[pg];
        isz = class_bytes[c];
        if (isz != 0 && off % isz == 0 && off / isz < slots_per_page[c]) begin
          s = pg * SLOTS_MAX + off / isz;
          if (slot_taken[s]) begin
            slot_taken[s] = 0;
            if (list_filled[c]) begin
              slot_link[s] = list_head[c];
              list_head[c] = s;
            end else begin
              list_head[c] = s;
              list_tail[c] = s;
              list_filled[c] = 1;
            end
            bytes_in_use -= isz;
            a.status = ST_OK;
            a.cls = CLS_W'(c);
            foreach (live_blocks[i]) begin
              if (live_blocks[i] == r.addr) begin
                live_blocks.delete(i);
                break;
              end
            end
          end
        end
      end
    end
    pb = longint'(carved_pages) * PAGE_BYTES;
    a.used = BYTES_W'(bytes_in_use);
    a.pages = BYTES_W'(pb);
    a.free = BYTES_W'(pb - bytes_in_use);
    return a;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Request driver: a new transfer is offered once the previous one is taken.
  always @(negedge clk) begin
    request_t r;
    if (!rst && (!req_valid || req_taken)) begin
      if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
        r = pending_requests[0];
        pending_requests.delete(0);
        req_valid <= 1;
        op <= r.op;
        request_size <= r.size;
        block_address <= r.addr;
      end else begin
        req_valid <= 0;
      end
    end
    rsp_ready <= !rst && (calm || $urandom_range(99) >= 11);
  end

  // Monitor: check the oldest expectation, then predict for a new request.
  always @(posedge clk) begin
    answer_t e;
    request_t r;
    req_taken <= req_valid && req_ready;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_answers.size() == 0) begin
        $error("response transfer with no request outstanding");
        errors++;
      end else begin
        e = awaited_answers[0];
        awaited_answers.delete(0);
        compare_field("status", e.status, status);
        compare_field("granted_address", e.granted, granted_address);
        compare_field("size_class", e.cls, size_class);
        compare_field("used_bytes", e.used, used_bytes);
        compare_field("page_bytes", e.pages, page_bytes);
        compare_field("free_bytes", e.free, free_bytes);
      end
    end
    if (!rst && req_valid && req_ready) begin
      r.op = op;
      r.size = request_size;
      r.addr = block_address;
      awaited_answers = {awaited_answers, serve_request(r)};
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_register(logic [APB_AW-1:0] a, logic [APB_DW-1:0] d);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (a == ADDR_POOL_LIMIT) limit_bytes = d & 32'h7FFFF;
    else growth_q88 = d & 32'hFFFF;
  endtask

  task automatic queue_request(logic [OP_W-1:0] o, logic [BYTES_W-1:0] sz,
                               logic [ADDR_W-1:0] ad);
    request_t r;
    r.op = o;
    r.size = sz;
    r.addr = ad;
    pending_requests = {pending_requests, r};
  endtask

  // Waits until every request has been answered and the block is quiet.
  task automatic drain;
    while (pending_requests.size() > 0 || req_valid || awaited_answers.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random traffic: mostly allocations and releases of live blocks.
  task automatic random_traffic(int count);
    int pick;
    logic [BYTES_W-1:0] sz;
    logic [ADDR_W-1:0] ad;
    for (int n = 0; n < count; n++) begin
      while (pending_requests.size() >= 2) @(posedge clk);
      pick = $urandom_range(99);
      sz = BYTES_W'($urandom);
      ad = ADDR_W'($urandom);
      if (pick < 50) begin
        pick = $urandom_range(99);
        if (pick < 5) sz = BYTES_W'($urandom_range(PAGE_BYTES + 1, 524287));
        else if (pick < 7) sz = '0;
        else if (pick < 55) sz = BYTES_W'($urandom_range(1, 64));
        else if (pick < 85) sz = BYTES_W'($urandom_range(65, 1024));
        else sz = BYTES_W'($urandom_range(1025, PAGE_BYTES));
        queue_request(OP_ALLOC, sz, ad);
      end else if (pick < 85) begin
        pick = $urandom_range(99);
        if (live_blocks.size() > 0 && pick < 85)
          ad = ADDR_W'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
        else if (live_blocks.size() > 0 && pick < 92)
          ad = ADDR_W'(live_blocks[$urandom_range(live_blocks.size() - 1)]
                       + $urandom_range(1, 7));
        queue_request(OP_RELEASE, sz, ad);
      end else if (pick < 95) begin
        queue_request(OP_QUERY, sz, ad);
      end else begin
        queue_request(OP_SPARE, sz, ad);
      end
    end
  endtask

  initial begin
    limit_bytes = POOL_LIMIT_RESET;
    growth_q88 = GROWTH_RESET;
    class_total = 0;
    carved_pages = 0;
    bytes_in_use = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Registers at their reset values, rewritten once to be explicit.
    write_register(ADDR_POOL_LIMIT, 262144);
    write_register(ADDR_GROWTH, 512);

    // Directed: zero, tiny, whole-page and oversized requests, releases, a query and a spare code.
    queue_request(OP_ALLOC, 0, 0);
    queue_request(OP_ALLOC, 1, 0);
    queue_request(OP_ALLOC, 8, 0);
    queue_request(OP_ALLOC, PAGE_BYTES, 0);
    queue_request(OP_ALLOC, PAGE_BYTES + 1, 0);
    queue_request(OP_ALLOC, 262144, 0);
    queue_request(OP_ALLOC, 19'h7FFFF, 18'h3FFFF);
    queue_request(OP_ALLOC, 100, 0);
    queue_request(OP_RELEASE, 0, 8);
    queue_request(OP_RELEASE, 0, 8);
    queue_request(OP_RELEASE, 0, 4);
    queue_request(OP_RELEASE, 0, PAGE_BYTES);
    queue_request(OP_RELEASE, 0, 18'h3FFFF);
    queue_request(OP_QUERY, 0, 0);
    queue_request(OP_SPARE, 19'h7FFFF, 18'h3FFFF);
    queue_request(OP_ALLOC, 7, 0);
    queue_request(OP_ALLOC, 3000, 0);
    drain();

    // A stretch with no idling on either side, then one with random idling.
    calm = 1;
    random_traffic(100);
    calm = 0;
    random_traffic(60);
    drain();

    // Steepest growth.
    write_register(ADDR_GROWTH, 65535);
    random_traffic(100);
    drain();

    // Small pool and the weakest factor: page and class refusals.
    write_register(ADDR_POOL_LIMIT, 16384);
    write_register(ADDR_GROWTH, 257);
    random_traffic(100);
    drain();

    // Empty pool: every allocation is refused.
    write_register(ADDR_POOL_LIMIT, 0);
    write_register(ADDR_GROWTH, 384);
    random_traffic(40);
    drain();

    write_register(ADDR_POOL_LIMIT, 200000);
    write_register(ADDR_GROWTH, 300);
    random_traffic(130);
    drain();

    write_register(ADDR_POOL_LIMIT, 262144);
    write_register(ADDR_GROWTH, 512);
    random_traffic(130);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ssca_pkg.sv
hw/rtl/ssca_div.sv
hw/rtl/ssca_datapath.sv
hw/rtl/ssca_ctrl.sv
hw/rtl/slab_size_class_allocator.sv
verif/testbench.sv
